>>> design/rlc_pkg.sv
// Shared constants and types for the run-length character compressor.
`timescale 1ns / 1ps

package rlc_pkg;

    localparam int COUNT_DIGITS = 5;
    localparam int CNT_W        = 4 * COUNT_DIGITS;
    localparam int DIG_IDX_W    = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;
    localparam int LEN_W        = 32;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]       CHAR_ZERO = 8'h30;
    localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_ONE   = {{(CNT_W-1){1'b0}}, 1'b1};

    // One queue entry: the run closed by a byte change or a full count (a) and the run
    // flushed at end of sequence (b). b is present only on the last byte.
    typedef struct packed {
        logic             a_valid;
        logic [7:0]       a_char;
        logic [CNT_W-1:0] a_cnt;
        logic             b_valid;
        logic [7:0]       b_char;
        logic [CNT_W-1:0] b_cnt;
    } flush_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHAR  = 3'b010,
        ST_DIGIT = 3'b100
    } back_state_t;

endpackage

>>> design/rlc_queue.sv
// Short queue of flush entries between the front and back parts.
`timescale 1ns / 1ps

module rlc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rlc_pkg::flush_entry_t push_entry,
    output logic                 full,
    input  logic                 pop,
    output rlc_pkg::flush_entry_t pop_entry,
    output logic                 empty
);
    import rlc_pkg::*;

    flush_entry_t      mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty     = (cnt_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> design/rlc_front.sv
// Front part: accepts input beats, tracks the open run, queues flush entries.
`timescale 1ns / 1ps

module rlc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_char,
    input  logic                 in_last,
    output logic                 push,
    output rlc_pkg::flush_entry_t push_entry,
    input  logic                 q_full
);
    import rlc_pkg::*;

    logic [7:0]       run_char_reg, run_char_next;
    logic [CNT_W-1:0] run_cnt_reg, run_cnt_next;
    logic             accept, run_open, cnt_full, extend;
    logic [CNT_W-1:0] cnt_inc, new_cnt;

    // BCD ripple increment, one digit at a time
    always_comb
    begin
        logic carry;
        carry   = 1'b1;
        cnt_inc = run_cnt_reg;
        for (int d = 0; d < COUNT_DIGITS; d++)
        begin
            if (carry)
            begin
                if (run_cnt_reg[4*d +: 4] == 4'd9)
                begin
                    cnt_inc[4*d +: 4] = 4'd0;
                end
                else
                begin
                    cnt_inc[4*d +: 4] = run_cnt_reg[4*d +: 4] + 4'd1;
                    carry             = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        cnt_full = 1'b1;
        for (int d = 0; d < COUNT_DIGITS; d++)
        begin
            if (run_cnt_reg[4*d +: 4] != 4'd9)
            begin
                cnt_full = 1'b0;
            end
        end
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign run_open = (run_cnt_reg != '0);
    assign extend   = run_open && (in_char == run_char_reg) && !cnt_full;
    assign new_cnt  = extend ? cnt_inc : CNT_ONE;

    always_comb
    begin
        push_entry.a_valid = run_open && !extend;
        push_entry.a_char  = run_char_reg;
        push_entry.a_cnt   = run_cnt_reg;
        push_entry.b_valid = in_last;
        push_entry.b_char  = in_char;
        push_entry.b_cnt   = new_cnt;
        push               = accept && (push_entry.a_valid || in_last);

        run_char_next = run_char_reg;
        run_cnt_next  = run_cnt_reg;
        if (accept)
        begin
            // end of sequence closes the run
            run_char_next = in_last ? 8'd0 : in_char;
            run_cnt_next  = in_last ? '0 : new_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_char_reg <= '0;
            run_cnt_reg  <= '0;
        end
        else
        begin
            run_char_reg <= run_char_next;
            run_cnt_reg  <= run_cnt_next;
        end
    end

endmodule

>>> design/rlc_back.sv
// Back part: expands flush entries into run bytes and decimal digits.
`timescale 1ns / 1ps

module rlc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    output logic                 pop,
    input  rlc_pkg::flush_entry_t pop_entry,
    input  logic                 q_empty,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_char,
    output logic                 out_last,
    output logic [31:0]          total_length
);
    import rlc_pkg::*;

    back_state_t          st_reg, st_next;
    flush_entry_t         ent_reg, ent_next;
    logic                 sel_b_reg, sel_b_next;
    logic [DIG_IDX_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_char_reg, out_char_next;
    logic                 out_last_reg, out_last_next;
    logic [LEN_W-1:0]     total_reg, total_next;

    logic [7:0]           cur_char;
    logic [CNT_W-1:0]     cur_cnt;
    logic [DIG_IDX_W-1:0] top_idx;
    logic                 multi, advance, flush_done, entry_done, final_beat;
    logic [7:0]           beat_char;
    logic [LEN_W-1:0]     len_inc;

    assign cur_char = sel_b_reg ? ent_reg.b_char : ent_reg.a_char;
    assign cur_cnt  = sel_b_reg ? ent_reg.b_cnt : ent_reg.a_cnt;
    assign multi    = (cur_cnt != '0) && (cur_cnt != CNT_ONE);

    always_comb
    begin
        top_idx = '0;
        for (int d = 0; d < COUNT_DIGITS; d++)
        begin
            if (cur_cnt[4*d +: 4] != 4'd0)
            begin
                top_idx = DIG_IDX_W'(d);
            end
        end
    end

    assign advance = (st_reg != ST_IDLE) && (!out_valid_reg || out_ready);
    assign len_inc = (len_reg == LEN_MAX) ? len_reg : len_reg + 1'b1;

    always_comb
    begin
        case (st_reg)
            ST_CHAR:
            begin
                beat_char  = cur_char;
                flush_done = !multi;
            end
            ST_DIGIT:
            begin
                beat_char  = CHAR_ZERO + {4'd0, cur_cnt[4*idx_reg +: 4]};
                flush_done = (idx_reg == '0);
            end
            default:
            begin
                beat_char  = 8'd0;
                flush_done = 1'b0;
            end
        endcase
    end

    assign final_beat = advance && flush_done && sel_b_reg;
    assign entry_done = advance && flush_done && (sel_b_reg || !ent_reg.b_valid);
    assign pop        = ((st_reg == ST_IDLE) || entry_done) && !q_empty;

    always_comb
    begin
        st_next    = st_reg;
        ent_next   = ent_reg;
        sel_b_next = sel_b_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;

        if (advance)
        begin
            len_next = final_beat ? '0 : len_inc;
            if (st_reg == ST_CHAR && multi)
            begin
                st_next  = ST_DIGIT;
                idx_next = top_idx;
            end
            else if (st_reg == ST_DIGIT && !flush_done)
            begin
                idx_next = idx_reg - 1'b1;
            end
            else if (flush_done && !entry_done)
            begin
                // move on to the end-of-sequence run
                st_next    = ST_CHAR;
                sel_b_next = 1'b1;
            end
            else
            begin
                st_next = ST_IDLE;
            end
        end

        if (pop)
        begin
            ent_next   = pop_entry;
            sel_b_next = !pop_entry.a_valid;
            st_next    = ST_CHAR;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        total_next     = total_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_char_next  = beat_char;
            out_last_next  = final_beat;
            total_next     = final_beat ? len_inc : '0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            sel_b_reg     <= 1'b0;
            idx_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            sel_b_reg     <= sel_b_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg      <= ent_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        total_reg    <= total_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_char     = out_char_reg;
    assign out_last     = out_last_reg;
    assign total_length = total_reg;

endmodule

>>> design/run_length_char_compressor.sv
// Usage notes:
// Input channel in_valid/in_ready carries one byte (in_char) per beat, with
// in_last on the final byte of a sequence. Output channel out_valid/out_ready
// carries compressed bytes: each run's byte, then its length in ASCII decimal
// (most significant digit first) when the run is longer than one. out_last
// marks the final byte of a sequence, and total_length then gives the
// compressed length (saturating at 2^32-1); it reads zero on other beats.
// Runs longer than 99999 are split into runs of 99999 and a remainder.
// Throughput: one input beat per cycle while the four-entry flush queue has
// room; output runs at one byte per cycle while out_ready is high and flush
// entries wait, as the back part's sequencer emits a flush's bytes one at a time.
// The first byte of a flush is written into the queue at the edge that accepts
// the input beat causing it, then loaded by the sequencer, then put in the output
// register, which raises out_valid.
// Reset clears the open run, the queue, the length count and the output valid
// flag. When the receiver stalls, the output register holds its beat, the
// sequencer waits, the queue fills and in_ready falls once it is full.
`timescale 1ns / 1ps

module run_length_char_compressor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_char,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        out_last,
    output logic [31:0] total_length
);
    import rlc_pkg::*;

    flush_entry_t push_entry, pop_entry;
    logic         push, pop, q_full, q_empty;

    rlc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_char    (in_char),
        .in_last    (in_last),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    rlc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    rlc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop          (pop),
        .pop_entry    (pop_entry),
        .q_empty      (q_empty),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_char     (out_char),
        .out_last     (out_last),
        .total_length (total_length)
    );

endmodule

>>> test/run_length_char_compressor_test.sv
// Self-checking testbench for the run-length character compressor: directed, random and stall tests.
`timescale 1ns / 1ps

module run_length_char_compressor_test;

    import rlc_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_ITEMS = 250;
    localparam logic [CNT_W-1:0] ALL_NINES = {COUNT_DIGITS{4'h9}};

    typedef struct packed {
        logic [7:0]       ch;
        logic             last;
        logic [LEN_W-1:0] len;
    } coded_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_char = 8'h00;
    logic        in_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_char;
    logic        out_last;
    logic [31:0] total_length;

    // predictor state
    logic [7:0]       cur_char = 8'h00;
    logic [CNT_W-1:0] cur_count = '0;
    logic [LEN_W-1:0] coded_len = '0;
    coded_beat_t      coded_bytes_due[$];

    int  fail_count = 0;
    int  beats_seen = 0;
    int  items_sent = 0;
    int  cycle_count = 0;
    bit  tx_gaps_on = 1'b1;
    bit  rx_gaps_on = 1'b1;
    int  hold_len = 0;
    int  hold_req_count = 0;
    int  hold_ack_count = 0;
    int  rx_hold_left = 0;
    int  rx_wait = 0;

    run_length_char_compressor uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_char      (in_char),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_char     (out_char),
        .out_last     (out_last),
        .total_length (total_length)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic log_fault(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // ---------------- predictor ----------------

    task automatic add_coded(input logic [7:0] b);
        coded_beat_t beat;
        if (coded_len != LEN_MAX)
            coded_len++;
        beat.ch = b;
        beat.last = 1'b0;
        beat.len = '0;
        coded_bytes_due.insert(coded_bytes_due.size(), beat);
    endtask

    // run byte, then its decimal length without leading zeros when longer than one
    task automatic close_run();
        int d;
        int top;
        add_coded(cur_char);
        if (cur_count > CNT_ONE)
        begin
            top = 0;
            for (d = COUNT_DIGITS - 1; d >= 0; d--)
            begin
                if (cur_count[4*d +: 4] != 4'h0)
                begin
                    top = d;
                    break;
                end
            end
            for (d = top; d >= 0; d--)
                add_coded(CHAR_ZERO + {4'h0, cur_count[4*d +: 4]});
        end
    endtask

    task automatic encode_byte(input logic [7:0] c, input logic last);
        coded_beat_t tail;
        logic        carry;
        int          d;
        int          tail_idx;
        if (cur_count != '0 && c == cur_char && cur_count != ALL_NINES)
        begin
            carry = 1'b1;
            for (d = 0; d < COUNT_DIGITS; d++)
            begin
                if (carry)
                begin
                    if (cur_count[4*d +: 4] == 4'h9)
                        cur_count[4*d +: 4] = 4'h0;
                    else
                    begin
                        cur_count[4*d +: 4] = cur_count[4*d +: 4] + 4'h1;
                        carry = 1'b0;
                    end
                end
            end
        end
        else
        begin
            if (cur_count != '0)
                close_run();
            cur_char = c;
            cur_count = CNT_ONE;
        end
        if (last)
        begin
            close_run();
            tail_idx = coded_bytes_due.size() - 1;
            tail = coded_bytes_due[tail_idx];
            tail.last = 1'b1;
            tail.len = coded_len;
            coded_bytes_due[tail_idx] = tail;
            cur_char = 8'h00;
            cur_count = '0;
            coded_len = '0;
        end
    endtask

    // ---------------- drivers ----------------

    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        in_valid <= 1'b1;
        in_char <= c;
        in_last <= last;
        do
            @(posedge clk);
        while (!in_ready);
        encode_byte(c, last);
        items_sent++;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_run(input logic [7:0] c, input int n, input logic last_at_end);
        int i;
        for (i = 0; i < n; i++)
            send_byte(c, last_at_end && (i == n - 1));
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: random gaps, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req_count != hold_ack_count)
        begin
            out_ready <= 1'b0;
            rx_hold_left = hold_len - 1;
            hold_ack_count = hold_req_count;
        end
        else if (rx_hold_left > 0)
        begin
            out_ready <= 1'b0;
            rx_hold_left--;
        end
        else if (!rx_gaps_on)
            out_ready <= 1'b1;
        else if (rx_wait > 0)
        begin
            out_ready <= 1'b0;
            rx_wait--;
        end
        else
        begin
            out_ready <= 1'b1;
            rx_wait = pick_gap();
        end
    end

    // ---------------- checker ----------------

    always @(posedge clk)
    begin
        coded_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            beats_seen++;
            if (coded_bytes_due.size() == 0)
                log_fault($sformatf("beat %0d: unexpected char %02h last %0b length %0d",
                                    beats_seen, out_char, out_last, total_length));
            else
            begin
                want = coded_bytes_due.pop_front();
                if (out_char !== want.ch || out_last !== want.last
                    || total_length !== want.len)
                    log_fault($sformatf(
                        "beat %0d: expected %02h/%0b/%0d, got %02h/%0b/%0d",
                        beats_seen, want.ch, want.last, want.len,
                        out_char, out_last, total_length));
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_directed();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_run("a", 2, 1'b0);
        send_byte("b", 1'b1);
        // a run of ten puts a zero digit out
        send_run("c", 10, 1'b0);
        send_run("d", 2, 1'b1);
        // digit-valued bytes, then a change on the last beat closes two runs
        send_run("7", 3, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h55, 1'b1);
    endtask

    task automatic test_digit_carry();
        tx_gaps_on = 1'b0;
        send_run("q", 99, 1'b1);
        // carry ripples into a third digit, two zero digits out
        send_run("r", 100, 1'b1);
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_output_hold_off();
        logic [7:0] c;
        logic [7:0] prev;
        int         i;
        prev = 8'h00;
        hold_len = 300;
        hold_req_count++;
        tx_gaps_on = 1'b0;
        for (i = 0; i < 40; i++)
        begin
            c = 8'($urandom);
            if (c == prev)
                c = ~c;
            send_byte(c, i == 39);
            prev = c;
        end
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_sequences();
        logic [7:0] c;
        int         start;
        int         runs;
        int         r;
        int         n;
        int         roll;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0)
            begin
                // noise: unstructured bytes and end flags
                repeat ($urandom_range(1, 12))
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
            else
            begin
                runs = $urandom_range(1, 8);
                for (r = 0; r < runs; r++)
                begin
                    if ($urandom_range(0, 1) == 0)
                        c = 8'("a" + $urandom_range(0, 3));
                    else
                        c = 8'($urandom);
                    roll = $urandom_range(0, 99);
                    if (roll < 70)
                        n = $urandom_range(1, 3);
                    else if (roll < 95)
                        n = $urandom_range(4, 15);
                    else
                        n = $urandom_range(16, 150);
                    send_run(c, n, r == runs - 1);
                end
            end
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_digit_carry();
        test_output_hold_off();
        test_random_sequences();
        // leave the stream in a closed state so nothing is held open
        send_byte(8'($urandom), 1'b1);
        idle_input();
        while (coded_bytes_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (coded_bytes_due.size() != 0)
            $display("%0d expected bytes never arrived", coded_bytes_due.size());
        if (fail_count == 0 && coded_bytes_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
